/* hw/rtl/message_deframer_core_macros.svh */
// Assertion macros shared by the deframer RTL.
`ifndef MESSAGE_DEFRAMER_CORE_MACROS_SVH
`define MESSAGE_DEFRAMER_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define MDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define MDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mdf_pkg.sv */
// Shared types and constants of the message deframer.
`default_nettype none

package mdf_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned TypeWidth     = 16;
   localparam int unsigned CountWidth    = 4;
   localparam int unsigned CsrIndexWidth = 2;

   // Header layout, little-endian fields.
   localparam int unsigned TypeAt   = 4;
   localparam int unsigned LenAt    = 6;
   localparam int unsigned HdrBytes = 10;

   localparam logic [WordWidth-1:0] MagicReset  = '0;
   localparam logic [WordWidth-1:0] MaxLenReset = '1;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_BAD   = 2'd2
   } kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_EXPECTED_MAGIC  = 2'd0,
      CSR_MAX_PAYLOAD_LEN = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                         valid;
      logic [CsrIndexWidth-1:0]     index;
      logic [WordWidth-1:0]         data;
   } csr_write_type;

   typedef struct packed {
      kind_type                     kind;
      logic [TypeWidth-1:0]         msg_type;
      logic [ByteWidth-1:0]         payload_byte;
      logic                         last;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/mdf_in_stage.sv */
// Input register for the request byte stream.
`default_nettype none

module mdf_in_stage (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [mdf_pkg::ByteWidth-1:0] req_byte,
   input  wire logic                          take,
   output      logic                          hold_valid,
   output      logic [mdf_pkg::ByteWidth-1:0] hold_byte
);

   logic                          valid_ff, valid_in;
   logic [mdf_pkg::ByteWidth-1:0] byte_ff;
   logic                          accept;

   assign req_ready  = !valid_ff || take;
   assign accept     = req_valid && req_ready;
   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         byte_ff <= req_byte;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/mdf_frame_engine.sv */
// Header collection, checks and payload tagging, one byte per cycle unless the output stalls a result.
`default_nettype none

module mdf_frame_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mdf_pkg::csr_write_type        csr_write,
   input  wire logic                          in_valid,
   input  wire logic [mdf_pkg::ByteWidth-1:0] in_byte,
   input  wire logic                          out_ready,
   output      logic                          take,
   output      logic                          rsp_valid,
   output      mdf_pkg::rsp_type              rsp
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_STUCK   = 2'd2
   } phase_type;

   localparam logic [mdf_pkg::CountWidth-1:0] CountLast =
      mdf_pkg::CountWidth'(mdf_pkg::HdrBytes - 1);
   localparam logic [mdf_pkg::CountWidth-1:0] CountType =
      mdf_pkg::CountWidth'(mdf_pkg::TypeAt);
   localparam logic [mdf_pkg::CountWidth-1:0] CountLen =
      mdf_pkg::CountWidth'(mdf_pkg::LenAt);

   phase_type                          phase_ff, phase_in;
   logic [mdf_pkg::CountWidth-1:0]     count_ff, count_in;
   logic [mdf_pkg::WordWidth-1:0]      left_ff, left_in;
   logic [mdf_pkg::WordWidth-1:0]      magic_ff, magic_in;
   logic [mdf_pkg::TypeWidth-1:0]      type_ff, type_in;
   logic [mdf_pkg::WordWidth-9:0]      len_lo_ff, len_lo_in;
   logic [mdf_pkg::WordWidth-1:0]      exp_magic_ff, max_len_ff;

   logic [mdf_pkg::WordWidth-1:0]      len_full;
   logic [mdf_pkg::CountWidth-1:0]     off_type, off_len;
   logic                               has_result, bad_hdr, fin;

   assign len_full = {in_byte, len_lo_ff};
   assign bad_hdr  = (magic_ff != exp_magic_ff) || (len_full > max_len_ff);
   assign fin      = (left_ff[mdf_pkg::WordWidth-1:1] == '0);
   assign off_type = count_ff - CountType;
   assign off_len  = count_ff - CountLen;

   always_comb begin
      has_result       = 1'b0;
      rsp.kind         = mdf_pkg::KIND_DATA;
      rsp.msg_type     = type_ff;
      rsp.payload_byte = '0;
      rsp.last         = 1'b1;
      unique case (phase_ff)
         PH_HEADER: begin
            // A good header with a payload ends silently.
            has_result = (count_ff == CountLast) && (bad_hdr || (len_full == '0));
            if (bad_hdr) begin
               rsp.kind = mdf_pkg::KIND_BAD;
            end else begin
               rsp.kind = mdf_pkg::KIND_EMPTY;
            end
         end
         PH_PAYLOAD: begin
            has_result       = 1'b1;
            rsp.payload_byte = in_byte;
            rsp.last         = fin;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // A byte with no result may pass even while the output is blocked.
   assign take      = in_valid && (out_ready || !has_result);
   assign rsp_valid = take && has_result;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      magic_in  = magic_ff;
      type_in   = type_ff;
      len_lo_in = len_lo_ff;
      if (take) begin
         unique case (phase_ff)
            PH_HEADER: begin
               priority if (count_ff < CountType) begin
                  magic_in[8*count_ff[1:0] +: 8] = in_byte;
               end else if (count_ff < CountLen) begin
                  type_in[8*off_type[0] +: 8] = in_byte;
               end else if (count_ff < CountLast) begin
                  len_lo_in[8*off_len[1:0] +: 8] = in_byte;
               end else begin
                  len_lo_in = len_lo_ff;
               end
               if (count_ff == CountLast) begin
                  count_in = '0;
                  if (bad_hdr) begin
                     phase_in = PH_STUCK;
                  end else if (len_full != '0) begin
                     phase_in = PH_PAYLOAD;
                     left_in  = len_full;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            PH_PAYLOAD: begin
               if (fin) begin
                  left_in  = '0;
                  phase_in = PH_HEADER;
               end else begin
                  left_in = left_ff - 1'b1;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         left_ff      <= '0;
         exp_magic_ff <= mdf_pkg::MagicReset;
         max_len_ff   <= mdf_pkg::MaxLenReset;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         if (csr_write.valid) begin
            if (csr_write.index == mdf_pkg::CSR_EXPECTED_MAGIC) begin
               exp_magic_ff <= csr_write.data;
            end else if (csr_write.index == mdf_pkg::CSR_MAX_PAYLOAD_LEN) begin
               max_len_ff <= csr_write.data;
            end
         end
      end
      magic_ff  <= magic_in;
      type_ff   <= type_in;
      len_lo_ff <= len_lo_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/mdf_out_stage.sv */
// Result register toward the response channel.
`default_nettype none

module mdf_out_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire mdf_pkg::rsp_type in_rsp,
   output      logic             in_ready,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      mdf_pkg::rsp_type rsp
);

   logic             valid_ff, valid_in;
   mdf_pkg::rsp_type rsp_ff;

   assign in_ready  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid) begin
         rsp_ff <= in_rsp;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/message_deframer_core.sv */
// Top level of the magic / type / length message deframer.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_byte_in
//   rsp       out        rsp_valid/rsp_ready    rsp_kind, rsp_msg_type,
//                                               rsp_payload_byte, rsp_last
//   csr       in         csr_valid/csr_ready    csr_index, csr_wdata
//
// One byte per cycle sustained while responses are accepted; a byte is held in
// the input register and its result in the output register.
// The header check is two 32-bit compares, magic and length, in the cycle of the tenth byte.
// Reset is synchronous; it clears the phase, counters and both registers' valid flags.
// A stalled response blocks only bytes that produce a result.
// csr_ready is always high; writes take effect at the next edge.
`default_nettype none
`include "message_deframer_core_macros.svh"

module message_deframer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic [mdf_pkg::ByteWidth-1:0]     req_byte_in,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [1:0]                        rsp_kind,
   output      logic [mdf_pkg::TypeWidth-1:0]     rsp_msg_type,
   output      logic [mdf_pkg::ByteWidth-1:0]     rsp_payload_byte,
   output      logic                              rsp_last,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [mdf_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [mdf_pkg::WordWidth-1:0]     csr_wdata
);

   mdf_pkg::csr_write_type        csr_write;
   logic                          hold_valid, take;
   logic [mdf_pkg::ByteWidth-1:0] hold_byte;
   logic                          eng_valid, out_ready;
   mdf_pkg::rsp_type              eng_rsp, out_rsp;

   assign csr_ready       = 1'b1;
   assign csr_write.valid = csr_valid && csr_ready;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_wdata;

   mdf_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_byte   (req_byte_in),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_byte  (hold_byte)
   );

   mdf_frame_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .in_valid  (hold_valid),
      .in_byte   (hold_byte),
      .out_ready (out_ready),
      .take      (take),
      .rsp_valid (eng_valid),
      .rsp       (eng_rsp)
   );

   mdf_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (eng_valid),
      .in_rsp    (eng_rsp),
      .in_ready  (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (out_rsp)
   );

   assign rsp_kind         = out_rsp.kind;
   assign rsp_msg_type     = out_rsp.msg_type;
   assign rsp_payload_byte = out_rsp.payload_byte;
   assign rsp_last         = out_rsp.last;

   `MDF_ASSERT_NOW(a_ctrl_last, clock, reset,
      rsp_valid && (rsp_kind != mdf_pkg::KIND_DATA), rsp_last,
      "empty or corrupted response without last")
   `MDF_ASSERT_NOW(a_ctrl_zero, clock, reset,
      rsp_valid && (rsp_kind != mdf_pkg::KIND_DATA), rsp_payload_byte == '0,
      "non-data response carries a payload byte")
   `MDF_ASSERT_NEXT(a_stuck_quiet, clock, reset,
      rsp_valid && rsp_ready && (rsp_kind == mdf_pkg::KIND_BAD), !rsp_valid,
      "response after a corrupted header")
   `MDF_ASSERT_NOW(a_in_free, clock, reset,
      !hold_valid, req_ready,
      "empty input register refuses a request")

endmodule

`default_nettype wire

/* dv/message_deframer_core_test.sv */
// Self-checking testbench for the magic / type / length message deframer.
`timescale 1ns / 100ps

module message_deframer_core_test;
   import mdf_pkg::*;

   localparam int unsigned CycleLimit   = 400000;
   localparam int unsigned RandomItems  = 1150;
   localparam int unsigned HoldOffAt    = 400;
   localparam int unsigned HoldOffLen   = 300;
   localparam int unsigned IdleSettle   = 4;
   localparam int unsigned DrainCycles  = 20;
   localparam int unsigned StuckBytes   = 30;
   localparam int unsigned NormalRows   = 6;

   // Register indexes the block does not decode.
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED_HI = 2'd3;

   typedef enum logic [1:0] {
      IN_HEADER,
      IN_BODY,
      LOCKED
   } frame_state_type;

   typedef struct packed {
      bit                   reprogram;
      logic [WordWidth-1:0] cfg_magic;
      logic [WordWidth-1:0] cfg_limit;
      logic [WordWidth-1:0] magic;
      logic [TypeWidth-1:0] mtype;
      logic [WordWidth-1:0] length;
      logic [ByteWidth-1:0] fill;
      bit                   typed;
      kind_type             want_kind;
   } frame_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [ByteWidth-1:0]       req_byte_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_kind;
   logic [TypeWidth-1:0]       rsp_msg_type;
   logic [ByteWidth-1:0]       rsp_payload_byte;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CsrIndexWidth-1:0]   csr_index = '0;
   logic [WordWidth-1:0]       csr_wdata = '0;

   message_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_msg_type     (rsp_msg_type),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Deframer prediction state and its copy of the registers.
   logic [WordWidth-1:0] magic_cfg = MagicReset;
   logic [WordWidth-1:0] len_limit = MaxLenReset;
   frame_state_type      frame_state = IN_HEADER;
   int unsigned          hdr_index = 0;
   logic [WordWidth-1:0] magic_acc = '0;
   logic [TypeWidth-1:0] type_acc = '0;
   logic [WordWidth-1:0] len_acc = '0;
   logic [WordWidth-1:0] body_left = '0;

   rsp_type     expected_rsps [$];
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned items_accepted = 0;
   int unsigned burst_left = 0;
   bit          hold_off_pending = 1'b0;

   // Directed frames; the last two corrupt the header and lock the block.
   frame_row_type directed_rows [0:7] = '{
      '{1'b0, 32'h0, 32'h0, 32'h0000_0000, 16'h0000, 32'd0, 8'h00, 1'b1, KIND_EMPTY},
      '{1'b0, 32'h0, 32'h0, 32'h0000_0000, 16'hFFFF, 32'd1, 8'hFF, 1'b0, KIND_DATA},
      '{1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'h1234, 32'd0, 8'h00, 1'b1,
        KIND_EMPTY},
      '{1'b1, 32'hA5C3_0F96, 32'd3, 32'hA5C3_0F96, 16'h8001, 32'd3, 8'hFE, 1'b0,
        KIND_DATA},
      '{1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 16'h00FF, 32'd2, 8'h7F,
        1'b0, KIND_DATA},
      '{1'b1, 32'h8000_0000, 32'd5, 32'h8000_0000, 16'h5A5A, 32'd0, 8'h00, 1'b1,
        KIND_EMPTY},
      '{1'b1, 32'h5A5A_1234, 32'hFFFF_FFFF, 32'h5A5A_1235, 16'h0BAD, 32'd0, 8'h00,
        1'b1, KIND_BAD},
      '{1'b1, 32'h0000_0007, 32'h0000_0010, 32'h0000_0007, 16'hFFFF, 32'hFFFF_FFFF,
        8'h00, 1'b1, KIND_BAD}
   };

   function automatic bit deframe_byte(input logic [ByteWidth-1:0] b, output rsp_type r);
      r = '0;
      case (frame_state)
         IN_HEADER: begin
            if (hdr_index < TypeAt)
               magic_acc[8*hdr_index +: 8] = b;
            else if (hdr_index < LenAt)
               type_acc[8*(hdr_index-TypeAt) +: 8] = b;
            else
               len_acc[8*(hdr_index-LenAt) +: 8] = b;
            hdr_index++;
            if (hdr_index < HdrBytes)
               return 1'b0;
            hdr_index = 0;
            r.msg_type = type_acc;
            r.last = 1'b1;
            if (magic_acc != magic_cfg || len_acc > len_limit) begin
               frame_state = LOCKED;
               r.kind = KIND_BAD;
               return 1'b1;
            end
            if (len_acc == 0) begin
               r.kind = KIND_EMPTY;
               magic_acc = '0;
               type_acc = '0;
               return 1'b1;
            end
            body_left = len_acc;
            frame_state = IN_BODY;
            return 1'b0;
         end
         IN_BODY: begin
            r.kind = KIND_DATA;
            r.msg_type = type_acc;
            r.payload_byte = b;
            r.last = (body_left <= 1);
            if (r.last) begin
               frame_state = IN_HEADER;
               magic_acc = '0;
               type_acc = '0;
               len_acc = '0;
            end else begin
               body_left--;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0d] %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic send_byte(input logic [ByteWidth-1:0] b, input bit use_want,
                            input rsp_type want);
      int unsigned gap;
      rsp_type     r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_accepted++;
      if (deframe_byte(b, r))
         expected_rsps.push_back(use_want ? want : r);
   endtask

   task automatic send_frame(input logic [WordWidth-1:0] magic,
                             input logic [TypeWidth-1:0] mtype,
                             input logic [WordWidth-1:0] length,
                             input logic [ByteWidth-1:0] fill, input bit random_body,
                             input bit typed, input rsp_type want);
      logic [79:0]          hdr_bits;
      logic [WordWidth-1:0] body_bytes;
      logic [WordWidth-1:0] i;
      logic [31:0]          noise;
      int                   k;
      hdr_bits = {length, mtype, magic};
      for (k = 0; k < HdrBytes; k++)
         send_byte(hdr_bits[8*k +: 8], typed, want);
      body_bytes = typed ? '0 : length;
      for (i = 0; i < body_bytes; i++) begin
         noise = $urandom;
         send_byte(random_body ? noise[7:0] : fill + i[7:0], 1'b0, '0);
      end
   endtask

   // Drop the request and hold until the block has nothing left in flight.
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (IdleSettle) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx,
                            input logic [WordWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_EXPECTED_MAGIC)
         magic_cfg = data;
      else if (idx == CSR_MAX_PAYLOAD_LEN)
         len_limit = data;
   endtask

   task automatic configure(input logic [WordWidth-1:0] magic,
                            input logic [WordWidth-1:0] limit);
      write_reg(CSR_EXPECTED_MAGIC, magic);
      write_reg(CSR_MAX_PAYLOAD_LEN, limit);
      // A stray write to an undecoded index must leave both registers alone.
      write_reg(($urandom_range(0, 1) == 0) ? CSR_UNUSED_LO : CSR_UNUSED_HI, $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic run_row(input frame_row_type row);
      rsp_type want;
      if (row.reprogram) begin
         wait_idle();
         configure(row.cfg_magic, row.cfg_limit);
      end
      want = '{kind: row.want_kind, msg_type: row.mtype, payload_byte: 8'h00,
               last: 1'b1};
      send_frame(row.magic, row.mtype, row.length, row.fill, 1'b0, row.typed, want);
   endtask

   // Response side: stall pattern in segments, plus one long hold-off on request.
   initial begin : drive_rsp_ready
      int unsigned seg_left;
      int unsigned stall_pct;
      int unsigned holdoff_left;
      seg_left = 0;
      stall_pct = 0;
      holdoff_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_left != 0) begin
            rsp_ready <= 1'b0;
            holdoff_left--;
         end else if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            holdoff_left = HoldOffLen - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(10, 80);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 75;
                  default: stall_pct = 50;
               endcase
            end
            seg_left--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d type %h byte %h last %0d",
                                      rsp_kind, rsp_msg_type, rsp_payload_byte, rsp_last));
         end else begin
            due = expected_rsps.pop_front();
            if (rsp_kind != due.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, due.kind));
            if (rsp_msg_type != due.msg_type)
               report_mismatch($sformatf("msg_type %h, want %h", rsp_msg_type,
                                         due.msg_type));
            if (rsp_payload_byte != due.payload_byte)
               report_mismatch($sformatf("payload_byte %h, want %h", rsp_payload_byte,
                                         due.payload_byte));
            if (rsp_last != due.last)
               report_mismatch($sformatf("last %0d, want %0d", rsp_last, due.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("message_deframer_core: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned          r;
      int unsigned          random_start;
      int unsigned          sel;
      logic [WordWidth-1:0] cap;
      logic [WordWidth-1:0] length;
      bit                   hold_off_done;
      hold_off_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < NormalRows; r++)
         run_row(directed_rows[r]);

      // Well-formed frames with random content under changing register settings.
      random_start = items_accepted;
      while (items_accepted - random_start < RandomItems) begin
         // Keep offering bytes while the long hold-off starts.
         if (!hold_off_pending && $urandom_range(0, 11) == 0) begin
            wait_idle();
            case ($urandom_range(0, 3))
               0: magic_cfg = '0;
               1: magic_cfg = '1;
               default: magic_cfg = $urandom;
            endcase
            case ($urandom_range(0, 5))
               0: len_limit = '0;
               1: len_limit = '1;
               2: len_limit = $urandom_range(1, 4);
               3: len_limit = $urandom;
               default: len_limit = $urandom_range(5, 60);
            endcase
            configure(magic_cfg, len_limit);
         end
         cap = (len_limit < 24) ? len_limit : 24;
         sel = $urandom_range(0, 19);
         if (len_limit == 0 || sel < 3)
            length = 0;
         else if (sel < 18)
            length = $urandom_range(1, cap);
         else
            length = $urandom_range(1, (len_limit < 200) ? len_limit : 200);
         send_frame(magic_cfg, TypeWidth'($urandom), length, 8'h00, 1'b1, 1'b0, '0);
         if (!hold_off_done && items_accepted - random_start >= HoldOffAt) begin
            hold_off_pending = 1'b1;
            hold_off_done = 1'b1;
         end
      end

      // Corrupt one header, then feed bytes the locked block must drop.
      wait_idle();
      run_row(directed_rows[$urandom_range(NormalRows, NormalRows + 1)]);
      repeat (StuckBytes) send_byte(ByteWidth'($urandom), 1'b0, '0);
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("message_deframer_core: match");
      else
         $display("message_deframer_core: mismatch");
      $finish;
   end

endmodule
